// ----- rtl/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg - shared types and constants of the process timer sleep scheduler
// Process count, sleep scale, channel payloads and the per-process record.
// ----------------------------------------------------------------------------
package pts_pkg;

    // table size and sleep unit
    localparam int NUM_PROCS   = 16;
    localparam int SLEEP_SCALE = 100;

    localparam int PID_W   = $clog2(NUM_PROCS);
    localparam int SCALE_W = $clog2(SLEEP_SCALE + 1);
    localparam int PROD_W  = 16 + SCALE_W;

    typedef logic [PID_W-1:0] t_addr;

    // operation codes
    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_TICK   = 2'd1,
        OP_SLEEP  = 2'd2,
        OP_GETPID = 2'd3
    } t_op;

    // process states
    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_READY = 2'd1,
        ST_SLEEP = 2'd2
    } t_pstat;

    // result status codes
    localparam logic STS_OK    = 1'b0;
    localparam logic STS_NOPID = 1'b1;

    typedef struct packed {
        t_op         operation;
        logic [3:0]  running_pid;
        logic [15:0] sleep_units;
    } t_in_item;

    typedef struct packed {
        logic       ready_valid;
        logic [3:0] ready_pid;
        logic       release_cpu;
        logic [3:0] pid_value;
        logic       status;
        logic       last;
    } t_out_item;

    // one entry of the process table
    typedef struct packed {
        t_pstat      st;
        logic [31:0] ticks;
        logic [31:0] wake;
    } t_rec;

endpackage

// ----- rtl/pts_in_if.sv -----
// ----------------------------------------------------------------------------
// pts_in_if - operation request channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface pts_in_if;
    import pts_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pts_out_if.sv -----
// ----------------------------------------------------------------------------
// pts_out_if - scheduler result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface pts_out_if;
    import pts_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/pts_cfg_if.sv -----
// ----------------------------------------------------------------------------
// pts_cfg_if - configuration write channel
// Valid/ready channel carrying the slice limit write data.
// ----------------------------------------------------------------------------
interface pts_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/process_timer_sleep_scheduler.sv -----
// ----------------------------------------------------------------------------
// process_timer_sleep_scheduler - process time manager for a small kernel
// Create, tick, sleep and get-pid operations over a process table in RAM.
//
//   channel  dir  handshake             payload
//   i_in     in   valid/ready           operation, running_pid, sleep_units
//   o_out    out  valid/ready           ready_valid .. last, one per result
//   i_cfg    in   valid/ready (ready=1) slice limit, 16 bits
//
// One item at a time. An active sleep reads the table entry, then writes it
// back. A tick reads and writes the running entry, then scans entries
// 1..NUM_PROCS-1 one per cycle on the RAM read port, unless a wake-up
// result is held up; an idle running pid skips the read and write, and a
// preempting tick adds a release step before the final result.
// Reset is synchronous; the table needs no clearing pass, per-entry valid
// bits make unwritten entries read as free with zero counts.
// A stalled result channel holds the scan; a one-entry output register
// lets the next item enter while the final result waits.
// ----------------------------------------------------------------------------
module process_timer_sleep_scheduler (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pts_in_if.sink    i_in,
    pts_out_if.source o_out,
    pts_cfg_if.sink   i_cfg
);
    import pts_pkg::*;

    localparam t_addr LAST_IDX = t_addr'(NUM_PROCS - 1);
    localparam int    REC_W    = $bits(t_rec);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ONE,
        S_CWR,
        S_RD,
        S_TMOD,
        S_SMOD,
        S_SCAN_RD,
        S_SCAN,
        S_PRE,
        S_TEND
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    t_addr               r_rp;
    logic [PROD_W-1:0]   r_prod;
    t_out_item           r_one;
    t_rec                r_rec;
    logic                r_preempt;
    t_addr               r_idx;
    logic                r_hold_v;
    t_out_item           r_hold;
    logic                r_out_v;
    t_out_item           r_out;
    logic [31:0]         r_now;
    t_addr               r_free_head;
    t_addr               r_free_count;
    logic [15:0]         r_slice;
    logic [NUM_PROCS-1:0] r_vld;
    logic                r_rd_vld;

    logic                ram_we;
    t_addr               ram_waddr;
    t_rec                ram_wdata;
    logic                ram_re;
    t_addr               ram_raddr;
    logic [REC_W-1:0]    ram_rdata;

    t_rec                rd_rec;
    logic                accept;
    logic                in_active;
    logic                can_push;
    logic                emit_ok;
    logic                wake_hit;
    logic                adv;
    logic [31:0]         tick_new;
    t_addr               create_pid;
    logic                push;
    t_out_item           push_data;
    logic                hold_load;
    t_out_item           hold_data;

    // process table
    pts_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_PROCS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshakes and per-cycle decisions
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign in_active   = (i_in.data.running_pid != 4'd0)
                      && (32'(i_in.data.running_pid) < NUM_PROCS);
    assign can_push    = !r_out_v || o_out.ready;
    assign emit_ok     = !r_hold_v || can_push;
    assign rd_rec      = r_rd_vld ? t_rec'(ram_rdata) : t_rec'('0);
    assign wake_hit    = (rd_rec.st == ST_SLEEP) && (rd_rec.wake == r_now);
    assign adv         = !wake_hit || emit_ok;
    assign tick_new    = rd_rec.ticks + 32'd1;
    assign create_pid  = r_free_head + t_addr'(1);

    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    // table port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_rp;
        ram_wdata = rd_rec;
        ram_re    = 1'b0;
        ram_raddr = r_rp;
        unique case (r_state)
            S_CWR: begin
                ram_we    = can_push;
                ram_wdata = '{st: ST_READY, ticks: '0, wake: '0};
            end
            S_RD: begin
                ram_re = 1'b1;
            end
            S_TMOD: begin
                ram_we    = 1'b1;
                ram_wdata = '{st: rd_rec.st, ticks: tick_new, wake: rd_rec.wake};
            end
            S_SMOD: begin
                ram_we    = can_push;
                ram_wdata = '{st: ST_SLEEP, ticks: rd_rec.ticks,
                              wake: r_now + 32'(r_prod)};
            end
            S_SCAN_RD: begin
                ram_re    = 1'b1;
                ram_raddr = t_addr'(1);
            end
            S_SCAN: begin
                ram_we    = adv && wake_hit;
                ram_waddr = r_idx;
                ram_wdata = '{st: ST_READY, ticks: rd_rec.ticks, wake: rd_rec.wake};
                ram_re    = adv && (r_idx != LAST_IDX);
                ram_raddr = r_idx + t_addr'(1);
            end
            S_PRE: begin
                ram_we    = emit_ok;
                ram_wdata = '{st: ST_READY, ticks: r_rec.ticks, wake: r_rec.wake};
            end
            default: begin
            end
        endcase
    end

    // result generation: tick results pass through a hold stage so that
    // the final one can carry last
    always_comb begin
        push      = 1'b0;
        push_data = r_one;
        hold_load = 1'b0;
        hold_data = '0;
        unique case (r_state)
            S_ONE, S_CWR: begin
                push = can_push;
            end
            S_SMOD: begin
                push      = can_push;
                push_data = '0;
                push_data.release_cpu = 1'b1;
                push_data.last        = 1'b1;
            end
            S_SCAN: begin
                hold_load = adv && wake_hit;
                push      = hold_load && r_hold_v;
                push_data = r_hold;
                hold_data.ready_valid = 1'b1;
                hold_data.ready_pid   = 4'(r_idx);
            end
            S_PRE: begin
                hold_load = emit_ok;
                push      = emit_ok && r_hold_v;
                push_data = r_hold;
                hold_data.ready_valid = 1'b1;
                hold_data.ready_pid   = 4'(r_rp);
                hold_data.release_cpu = 1'b1;
            end
            S_TEND: begin
                push      = can_push;
                push_data = r_hold_v ? r_hold : t_out_item'('0);
                push_data.last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hold_v     <= 1'b0;
            r_out_v      <= 1'b0;
            r_now        <= '0;
            r_free_head  <= '0;
            r_free_count <= LAST_IDX;
            r_slice      <= 16'd10;
            r_vld        <= '0;
            r_preempt    <= 1'b0;
        end else begin
            // configuration transfer
            if (i_cfg.valid) begin
                r_slice <= i_cfg.data;
            end

            // valid bits and read-data qualifier
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_vld <= r_vld[ram_raddr];
            end

            // output register
            r_out_v <= push || (r_out_v && !o_out.ready);
            if (push) begin
                r_out <= push_data;
            end

            // hold stage
            if (hold_load) begin
                r_hold_v <= 1'b1;
                r_hold   <= hold_data;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op      <= i_in.data.operation;
                        r_rp      <= (i_in.data.operation == OP_CREATE) ? create_pid
                                     : t_addr'(i_in.data.running_pid);
                        r_preempt <= 1'b0;
                        r_prod    <= PROD_W'(i_in.data.sleep_units * SLEEP_SCALE);
                        unique case (i_in.data.operation)
                            OP_CREATE: begin
                                if (r_free_count == '0) begin
                                    r_one   <= '{ready_valid: 1'b0, ready_pid: 4'd0,
                                                 release_cpu: 1'b0, pid_value: 4'd0,
                                                 status: STS_NOPID, last: 1'b1};
                                    r_state <= S_ONE;
                                end else begin
                                    r_free_head  <= create_pid;
                                    r_free_count <= r_free_count - t_addr'(1);
                                    r_one   <= '{ready_valid: 1'b1,
                                                 ready_pid: 4'(create_pid),
                                                 release_cpu: 1'b0,
                                                 pid_value: 4'(create_pid),
                                                 status: STS_OK, last: 1'b1};
                                    r_state <= S_CWR;
                                end
                            end
                            OP_TICK: begin
                                r_now   <= r_now + 32'd1;
                                r_state <= in_active ? S_RD : S_SCAN_RD;
                            end
                            OP_SLEEP: begin
                                r_one   <= '{ready_valid: 1'b0, ready_pid: 4'd0,
                                             release_cpu: 1'b0, pid_value: 4'd0,
                                             status: STS_OK, last: 1'b1};
                                r_state <= in_active ? S_RD : S_ONE;
                            end
                            OP_GETPID: begin
                                r_one   <= '{ready_valid: 1'b0, ready_pid: 4'd0,
                                             release_cpu: 1'b0,
                                             pid_value: i_in.data.running_pid,
                                             status: STS_OK, last: 1'b1};
                                r_state <= S_ONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    priority if (r_op == OP_TICK) begin
                        r_state <= S_TMOD;
                    end else begin
                        r_state <= S_SMOD;
                    end
                end
                S_TMOD: begin
                    // charge the running pid and test the slice
                    r_rec     <= '{st: rd_rec.st, ticks: tick_new, wake: rd_rec.wake};
                    r_preempt <= (tick_new == 32'(r_slice));
                    r_state   <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    r_idx   <= t_addr'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // wake scan, one entry per cycle unless a wake-up result is held up
                    if (adv) begin
                        if (r_idx == LAST_IDX) begin
                            r_state <= r_preempt ? S_PRE : S_TEND;
                        end else begin
                            r_idx <= r_idx + t_addr'(1);
                        end
                    end
                end
                S_PRE: begin
                    if (emit_ok) begin
                        r_state <= S_TEND;
                    end
                end
                S_TEND: begin
                    if (can_push) begin
                        r_hold_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_ONE, S_CWR, S_SMOD: begin
                    if (can_push) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // no tick result left over when a new item enters
    a_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !r_hold_v)
        else $error("hold stage still occupied at item transfer");

    // scan writes one entry while reading the next, never the same one
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("table read and write hit the same entry");

    // free list head and count move together
    a_free_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        t_addr'(r_free_head + r_free_count) == LAST_IDX)
        else $error("free list head and count out of step");

    // preemption state only entered with a pending preemption
    a_pre_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRE) |-> r_preempt)
        else $error("preemption without slice expiry");

endmodule

// ----- rtl/pts_ram.sv -----
// ----------------------------------------------------------------------------
// pts_ram - generic simple dual-port RAM
// One write port, one read port with registered read data held while idle.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - testbench of the process timer sleep scheduler
// Drives create, tick, sleep and get-pid requests with random gaps and
// result-side stalls. A class keeps its own copy of the process table, time
// and free list, predicts every result and checks each result transfer in
// order. The slice limit is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import pts_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;

    // process table copy, result prediction and in-order result checking
    class sched_table_model;
        logic [15:0] slice_limit;
        t_pstat      pstate   [NUM_PROCS];
        logic [31:0] cpu_ticks[NUM_PROCS];
        logic [31:0] wake_at  [NUM_PROCS];
        logic [31:0] now_ticks;
        t_addr       free_list[NUM_PROCS];
        int          free_head;
        int          free_count;
        t_out_item   due_results[$];
        int          mismatches;
        int          n_requests, n_results, n_wakeups, n_preempts, n_nopid;

        function new();
            slice_limit = 16'd10;
            now_ticks   = '0;
            for (int i = 0; i < NUM_PROCS; i++) begin
                pstate[i]    = ST_FREE;
                cpu_ticks[i] = '0;
                wake_at[i]   = '0;
                free_list[i] = (i + 1 < NUM_PROCS) ? t_addr'(i + 1) : '0;
            end
            free_head  = 0;
            free_count = NUM_PROCS - 1;
            mismatches = 0;
            n_requests = 0;
            n_results  = 0;
            n_wakeups  = 0;
            n_preempts = 0;
            n_nopid    = 0;
        endfunction

        function void set_slice_limit(logic [15:0] value);
            slice_limit = value;
        endfunction

        // one accepted request: update the table and queue what it must produce
        function void note_request(t_in_item req);
            t_out_item outs[NUM_PROCS + 1];
            int        n;
            logic [3:0] rp;
            bit        active;
            bit        preempt;
            t_addr     pid;
            n       = 0;
            rp      = req.running_pid;
            active  = (rp != 0) && (int'(rp) < NUM_PROCS);
            preempt = 0;
            n_requests++;
            for (int i = 0; i <= NUM_PROCS; i++) outs[i] = '0;
            case (req.operation)
                OP_CREATE: begin
                    if (free_count == 0) begin
                        outs[0].status = STS_NOPID;
                        n_nopid++;
                    end else begin
                        pid        = free_list[free_head];
                        free_head  = (free_head + 1) % NUM_PROCS;
                        free_count--;
                        cpu_ticks[pid] = '0;
                        wake_at[pid]   = '0;
                        pstate[pid]    = ST_READY;
                        outs[0].ready_valid = 1'b1;
                        outs[0].ready_pid   = pid;
                        outs[0].pid_value   = pid;
                        outs[0].status      = STS_OK;
                    end
                    n = 1;
                end
                OP_TICK: begin
                    if (active) begin
                        cpu_ticks[rp] = cpu_ticks[rp] + 32'd1;
                        preempt = (cpu_ticks[rp] == {16'h0, slice_limit});
                    end
                    now_ticks = now_ticks + 32'd1;
                    // wake-ups in ascending pid order
                    for (int i = 1; i < NUM_PROCS; i++) begin
                        if (pstate[i] == ST_SLEEP && wake_at[i] == now_ticks) begin
                            pstate[i] = ST_READY;
                            outs[n].ready_valid = 1'b1;
                            outs[n].ready_pid   = 4'(i);
                            n++;
                            n_wakeups++;
                        end
                    end
                    if (preempt) begin
                        pstate[rp] = ST_READY;
                        outs[n].ready_valid = 1'b1;
                        outs[n].ready_pid   = rp;
                        outs[n].release_cpu = 1'b1;
                        n++;
                        n_preempts++;
                    end
                    if (n == 0) n = 1;
                end
                OP_SLEEP: begin
                    if (active) begin
                        wake_at[rp] = now_ticks + 32'(SLEEP_SCALE) * {16'h0, req.sleep_units};
                        pstate[rp]  = ST_SLEEP;
                        outs[0].release_cpu = 1'b1;
                    end
                    n = 1;
                end
                default: begin
                    outs[0].pid_value = rp;
                    n = 1;
                end
            endcase
            outs[n - 1].last = 1'b1;
            for (int i = 0; i < n; i++) due_results.push_back(outs[i]);
        endfunction

        // one result transfer against the oldest expectation
        function void check_result(t_out_item got);
            t_out_item want;
            n_results++;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result rv=%0d rp=%0d rel=%0d pid=%0d st=%0d last=%0d",
                         $time, got.ready_valid, got.ready_pid, got.release_cpu,
                         got.pid_value, got.status, got.last);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got !== want) begin
                $display("%0t: result mismatch expected rv=%0d rp=%0d rel=%0d pid=%0d st=%0d last=%0d",
                         $time, want.ready_valid, want.ready_pid, want.release_cpu,
                         want.pid_value, want.status, want.last);
                $display("%0t:                 actual   rv=%0d rp=%0d rel=%0d pid=%0d st=%0d last=%0d",
                         $time, got.ready_valid, got.ready_pid, got.release_cpu,
                         got.pid_value, got.status, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pts_in_if  op_ch ();
    pts_out_if res_ch ();
    pts_cfg_if cfg_ch ();

    sched_table_model model;
    int               idle_cycles;

    process_timer_sleep_scheduler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // input gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [3:0] pick_pid();
        if ($urandom_range(0, 4) == 0) return 4'd0;
        return 4'($urandom_range(1, NUM_PROCS - 1));
    endfunction

    function automatic logic [15:0] pick_amount();
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 2));
    endfunction

    // one request transfer; returns on the falling edge after acceptance
    task automatic send_request(t_op op, logic [3:0] pid, logic [15:0] amount);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            op_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        op_ch.valid             = 1'b1;
        op_ch.data.operation    = op;
        op_ch.data.running_pid  = pid;
        op_ch.data.sleep_units  = amount;
        do @(posedge i_clk); while (!op_ch.ready);
        model.note_request(op_ch.data);
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_request(OP_TICK, pick_pid(), 16'($urandom_range(0, 65535)));
    endtask

    // wait for the block to drain, then write the slice limit
    task automatic write_slice_limit(logic [15:0] value);
        op_ch.valid = 1'b0;
        while (model.due_results.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        model.set_slice_limit(value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // random mix of all operations
    task automatic run_random_mix(int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 45)      send_tick();
            else if (r < 60) send_request(OP_SLEEP, pick_pid(), pick_amount());
            else if (r < 75) send_request(OP_CREATE, pick_pid(), pick_amount());
            else             send_request(OP_GETPID, pick_pid(), pick_amount());
        end
    endtask

    // result transfers are checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) model.check_result(res_ch.data);
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: ready runs broken by short and occasional long stalls
    initial begin
        int run_len;
        int stall_len;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
            res_ch.ready = 1'b1;
            repeat (run_len) @(negedge i_clk);
            stall_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                     : $urandom_range(10, 40);
            res_ch.ready = 1'b0;
            repeat (stall_len) @(negedge i_clk);
        end
    end

    // main sequence
    initial begin
        model        = new();
        idle_cycles  = 0;
        i_rst_n      = 1'b0;
        op_ch.valid  = 1'b0;
        op_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: idle pid, extremes of pid and amount, preemption at limit
        write_slice_limit(16'd3);
        // free pids put to sleep still wake after one unit, both on one tick
        send_request(OP_SLEEP, 4'd4, 16'h0001);
        send_request(OP_SLEEP, 4'hF, 16'h0001);
        send_request(OP_GETPID, 4'd0, 16'h0000);
        send_request(OP_GETPID, 4'hF, 16'hFFFF);
        send_request(OP_SLEEP, 4'd0, 16'hFFFF);
        send_tick();
        send_request(OP_CREATE, 4'd0, 16'h0000);
        send_request(OP_CREATE, 4'hF, 16'hFFFF);
        send_request(OP_CREATE, 4'd7, 16'h5A5A);
        repeat (4) send_request(OP_TICK, 4'd1, 16'h0000);
        // zero sleep never wakes before wrap, maximum sleep is far off
        send_request(OP_SLEEP, 4'd2, 16'h0000);
        send_request(OP_SLEEP, 4'd3, 16'hFFFF);
        send_request(OP_GETPID, 4'd5, 16'hA5A5);
        send_request(OP_TICK, 4'd2, 16'hFFFF);

        // random mix at both limit extremes
        write_slice_limit(16'd1);
        run_random_mix(5);
        write_slice_limit(16'hFFFF);
        run_random_mix(5);

        // ticks until the early sleepers are due
        write_slice_limit(16'($urandom_range(2, 20)));
        while (model.now_ticks < 32'd100) send_tick();

        // use up the free list, then create with none left
        while (model.free_count > 0) send_request(OP_CREATE, pick_pid(), pick_amount());
        repeat (2) send_request(OP_CREATE, pick_pid(), pick_amount());

        op_ch.valid = 1'b0;
        while (model.due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d requests, %0d results: %0d wake-ups, %0d preemptions,",
                 model.n_requests, model.n_results, model.n_wakeups, model.n_preempts);
        $display("%0d creates refused on an empty free list, %0d mismatches",
                 model.n_nopid, model.mismatches);
        if (model.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
